/* src/ehalloc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ehalloc_pkg;

    localparam int MAX_HANDLES = 64;
    localparam int MASK_BITS   = 32;
    localparam int ID_W        = $clog2(MAX_HANDLES);
    localparam int CNT_W       = ID_W + 1;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_SET   = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_W-1:0]      handle;
        logic [ID_W-1:0]      slot;
        logic [CNT_W-1:0]     live;
        logic [MASK_BITS-1:0] mask;
    } result_t;

endpackage

`default_nettype wire

/* src/entity_handle_allocator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Handle allocator over a dense table. Allocate hands out the first id of the free pool and
// records it with its mask at the next dense slot; free moves the last dense entry into the
// hole and returns the id to the pool; set and clear update a live handle's mask. Requests
// are taken one at a time: in_stall is high from the accepting edge until the result has
// been loaded into the output register. After the read state, allocate and free pass through
// the write-back state and set and clear through the mask state, from which the result is
// registered when the output is not stalled, else it waits in the output state; a full table
// or an absent handle answers from the read state. The read state writes the tables after
// their synchronous read, and the write-back state makes a second write to the pool tables for
// the swap (one write port each). After reset the tables need no clearing pass: per-entry
// flags in flip-flops stand in for the reset contents of the pool and of its inverse.
module entity_handle_allocator_unit
    import ehalloc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           func,
    input  wire logic [ID_W-1:0]      entity_id,
    input  wire logic [MASK_BITS-1:0] component_mask,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic [ID_W-1:0]           handle_out,
    output logic [ID_W-1:0]           dense_slot,
    output logic [CNT_W-1:0]          live_count,
    output logic [MASK_BITS-1:0]      mask_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_MASK = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [CNT_W-1:0] LIVE_MAX = CNT_W'(MAX_HANDLES);

    // table memories
    logic [ID_W-1:0]      pool_mem [MAX_HANDLES];
    logic [ID_W-1:0]      ppos_mem [MAX_HANDLES];
    logic [ID_W-1:0]      itos_mem [MAX_HANDLES];
    logic [ID_W-1:0]      stoi_mem [MAX_HANDLES];
    logic [MASK_BITS-1:0] mask_mem [MAX_HANDLES];

    logic [MAX_HANDLES-1:0] pool_set_reg, pool_set_next;
    logic [MAX_HANDLES-1:0] ppos_set_reg, ppos_set_next;
    logic [MAX_HANDLES-1:0] live_bit_reg, live_bit_next;

    logic [2:0]           state_reg, state_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic [1:0]           func_reg;
    logic [ID_W-1:0]      eid_reg;
    logic [MASK_BITS-1:0] cm_reg;
    logic [ID_W-1:0]      addr_a_reg;
    logic [ID_W-1:0]      addr_b_reg;
    logic [ID_W-1:0]      hold_a_reg;
    logic [ID_W-1:0]      hold_b_reg;
    logic [ID_W-1:0]      slot_reg;
    result_t              pend_reg;
    result_t              out_reg;
    logic                 out_valid_reg;

    // read data
    logic [ID_W-1:0]      pool_a_rd_reg, pool_b_rd_reg, ppos_rd_reg, itos_rd_reg, stoi_rd_reg;
    logic                 pool_a_hit_reg, pool_b_hit_reg, ppos_hit_reg;
    logic [MASK_BITS-1:0] mask_rd_reg;

    logic [ID_W-1:0]      addr_a_in, addr_b_in, last_slot_in, live_slot, mask_ra;
    logic [ID_W-1:0]      pool_a_val, pool_b_val, pos_val;
    logic                 accept, out_free, present, full;
    logic                 done, out_load;
    result_t              res, out_data;
    logic [MASK_BITS-1:0] new_mask;

    logic                 pool_we, ppos_we, itos_we, stoi_we, mask_we;
    logic [ID_W-1:0]      pool_wa, pool_wd, ppos_wa, ppos_wd, itos_wa, itos_wd;
    logic [ID_W-1:0]      stoi_wa, stoi_wd, mask_wa;
    logic [MASK_BITS-1:0] mask_wd;
    logic                 bit_set_we, bit_clr_we;
    logic [ID_W-1:0]      bit_set_a, bit_clr_a;

    assign accept       = in_valid && (state_reg == S_IDLE);
    assign in_stall     = (state_reg != S_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign live_slot    = live_reg[ID_W-1:0];
    assign last_slot_in = ID_W'(live_reg - CNT_W'(1));
    assign addr_a_in    = (func == FUNC_ALLOC) ? '0 : ID_W'(LIVE_MAX - live_reg);
    assign addr_b_in    = ID_W'(LIVE_MAX - live_reg - CNT_W'(1));
    assign mask_ra      = (state_reg == S_IDLE) ? last_slot_in : itos_rd_reg;

    assign pool_a_val = pool_a_hit_reg ? pool_a_rd_reg : addr_a_reg;
    assign pool_b_val = pool_b_hit_reg ? pool_b_rd_reg : addr_b_reg;
    assign pos_val    = ppos_hit_reg ? ppos_rd_reg : eid_reg;
    assign present    = live_bit_reg[eid_reg];
    assign full       = (live_reg == LIVE_MAX);
    assign new_mask   = (func_reg == FUNC_SET) ? (mask_rd_reg | cm_reg) : (mask_rd_reg & ~cm_reg);

    always_comb
    begin
        state_next    = state_reg;
        live_next     = live_reg;
        pool_set_next = pool_set_reg;
        ppos_set_next = ppos_set_reg;
        live_bit_next = live_bit_reg;
        res           = '0;
        done          = 1'b0;
        out_load      = 1'b0;
        out_data      = pend_reg;
        pool_we = 1'b0; pool_wa = '0; pool_wd = '0;
        ppos_we = 1'b0; ppos_wa = '0; ppos_wd = '0;
        itos_we = 1'b0; itos_wa = '0; itos_wd = '0;
        stoi_we = 1'b0; stoi_wa = '0; stoi_wd = '0;
        mask_we = 1'b0; mask_wa = '0; mask_wd = '0;
        bit_set_we = 1'b0; bit_set_a = '0;
        bit_clr_we = 1'b0; bit_clr_a = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (full)
                    begin
                        res  = '{status: ST_FULL, handle: '0, slot: '0, live: live_reg, mask: '0};
                        done = 1'b1;
                    end
                    else
                    begin
                        pool_we = 1'b1; pool_wa = addr_a_reg; pool_wd = pool_b_val;
                        ppos_we = 1'b1; ppos_wa = pool_b_val; ppos_wd = addr_a_reg;
                        itos_we = 1'b1; itos_wa = pool_a_val; itos_wd = live_slot;
                        stoi_we = 1'b1; stoi_wa = live_slot;  stoi_wd = pool_a_val;
                        mask_we = 1'b1; mask_wa = live_slot;  mask_wd = cm_reg;
                        bit_set_we = 1'b1; bit_set_a = pool_a_val;
                        live_next  = live_reg + CNT_W'(1);
                        state_next = S_WB;
                    end
                end
                else if (!present)
                begin
                    res  = '{status: ST_ABSENT, handle: eid_reg, slot: '0, live: live_reg, mask: '0};
                    done = 1'b1;
                end
                else if (func_reg == FUNC_FREE)
                begin
                    // last dense entry moves into the hole
                    itos_we = 1'b1; itos_wa = stoi_rd_reg; itos_wd = itos_rd_reg;
                    stoi_we = 1'b1; stoi_wa = itos_rd_reg; stoi_wd = stoi_rd_reg;
                    mask_we = 1'b1; mask_wa = itos_rd_reg; mask_wd = mask_rd_reg;
                    bit_set_we = 1'b1; bit_set_a = stoi_rd_reg;
                    bit_clr_we = 1'b1; bit_clr_a = eid_reg;
                    pool_we = 1'b1; pool_wa = addr_a_reg; pool_wd = eid_reg;
                    ppos_we = 1'b1; ppos_wa = eid_reg;    ppos_wd = addr_a_reg;
                    live_next  = live_reg - CNT_W'(1);
                    state_next = S_WB;
                end
                else
                begin
                    state_next = S_MASK;
                end
            end
            S_WB:
            begin
                // second half of the pool swap
                pool_we = 1'b1; pool_wa = hold_b_reg; pool_wd = hold_a_reg;
                ppos_we = 1'b1; ppos_wa = hold_a_reg; ppos_wd = hold_b_reg;
                if (func_reg == FUNC_ALLOC)
                begin
                    res = '{status: ST_OK, handle: hold_a_reg, slot: slot_reg,
                            live: live_reg, mask: cm_reg};
                end
                else
                begin
                    res = '{status: ST_OK, handle: eid_reg, slot: '0, live: live_reg, mask: '0};
                end
                done = 1'b1;
            end
            S_MASK:
            begin
                mask_we = 1'b1; mask_wa = slot_reg; mask_wd = new_mask;
                res  = '{status: ST_OK, handle: eid_reg, slot: slot_reg,
                         live: live_reg, mask: new_mask};
                done = 1'b1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                out_data   = res;
                state_next = S_IDLE;
            end
            else
            begin
                state_next = S_OUT;
            end
        end

        if (pool_we)
        begin
            pool_set_next[pool_wa] = 1'b1;
        end
        if (ppos_we)
        begin
            ppos_set_next[ppos_wa] = 1'b1;
        end
        if (bit_set_we)
        begin
            live_bit_next[bit_set_a] = 1'b1;
        end
        if (bit_clr_we)
        begin
            live_bit_next[bit_clr_a] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            live_reg      <= '0;
            pool_set_reg  <= '0;
            ppos_set_reg  <= '0;
            live_bit_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            live_reg     <= live_next;
            pool_set_reg <= pool_set_next;
            ppos_set_reg <= ppos_set_next;
            live_bit_reg <= live_bit_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            eid_reg    <= entity_id;
            cm_reg     <= component_mask;
            addr_a_reg <= addr_a_in;
            addr_b_reg <= addr_b_in;
        end
        if (state_reg == S_READ)
        begin
            hold_a_reg <= pool_a_val;
            hold_b_reg <= (func_reg == FUNC_ALLOC) ? addr_b_reg : pos_val;
            slot_reg   <= (func_reg == FUNC_ALLOC) ? live_slot : itos_rd_reg;
        end
        if (done && !out_free)
        begin
            pend_reg <= res;
        end
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

    // pool and its inverse
    always_ff @(posedge clk)
    begin
        if (pool_we)
        begin
            pool_mem[pool_wa] <= pool_wd;
        end
        if (state_reg == S_IDLE)
        begin
            pool_a_rd_reg  <= pool_mem[addr_a_in];
            pool_b_rd_reg  <= pool_mem[addr_b_in];
            pool_a_hit_reg <= pool_set_reg[addr_a_in];
            pool_b_hit_reg <= pool_set_reg[addr_b_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ppos_we)
        begin
            ppos_mem[ppos_wa] <= ppos_wd;
        end
        if (state_reg == S_IDLE)
        begin
            ppos_rd_reg  <= ppos_mem[entity_id];
            ppos_hit_reg <= ppos_set_reg[entity_id];
        end
    end

    // sparse and dense maps
    always_ff @(posedge clk)
    begin
        if (itos_we)
        begin
            itos_mem[itos_wa] <= itos_wd;
        end
        if (state_reg == S_IDLE)
        begin
            itos_rd_reg <= itos_mem[entity_id];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stoi_we)
        begin
            stoi_mem[stoi_wa] <= stoi_wd;
        end
        if (state_reg == S_IDLE)
        begin
            stoi_rd_reg <= stoi_mem[last_slot_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_wa] <= mask_wd;
        end
        if ((state_reg == S_IDLE) || (state_reg == S_READ))
        begin
            mask_rd_reg <= mask_mem[mask_ra];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign handle_out = out_reg.handle;
    assign dense_slot = out_reg.slot;
    assign live_count = out_reg.live;
    assign mask_out   = out_reg.mask;

endmodule

`default_nettype wire
